@@ sv/tcce_pkg.sv @@
// tcce_pkg: shared types and constants of the text console character engine
// no dependencies

package tcce_pkg;

  localparam int OP_W        = 1;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = CHAR_W + ATTR_W;
  localparam int CELL_IDX_W  = 11;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int TAB_STOP    = 8;
  localparam int TAB_N_W     = 3;

  localparam logic [OP_W-1:0]   OP_PRINT   = 1'b0;
  localparam logic [OP_W-1:0]   OP_READ    = 1'b1;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [CFG_ADDR_W-1:0] REG_ADDR_TEXT_ATTR = 2'd0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_BLANK,
    S_COPY,
    S_DRAIN,
    S_FILL,
    S_DONE
  } tcce_state_t;

endpackage

@@ sv/text_console_character_engine.sv @@
// text_console_character_engine: top level of the text console character engine
// depends on tcce_pkg, tcce_ram and tcce_seq
//
// Text console of ROWS_N x COLUMNS_N cells held in a synchronous cell store. After
// reset the store is cleared one cell per cycle, during which no item is taken. A
// print item of a plain character, newline or carriage return passes through the
// idle and done states, a read item through idle, read and done, and a tab through
// idle, one blank step per cell it blanks (up to 7) and done. A print that runs the
// cursor past the last row also scrolls: the store is copied up one row through its
// single read and write port, then the bottom row is blanked. One item is worked on
// at a time; a finished result waits in the output register while the next item
// is taken. The text attribute register sits at byte address 0 of the APB port.

module text_console_character_engine import tcce_pkg::*; #(
  parameter int ROWS_N    = 25,
  parameter int COLUMNS_N = 80
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [OP_W-1:0]       operation,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [CELL_IDX_W-1:0] cell_index,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [CELL_IDX_W-1:0] cursor_position,
  output logic [CHAR_W-1:0]     cell_char,
  output logic [ATTR_W-1:0]     cell_attr,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CELLS = ROWS_N * COLUMNS_N;
  localparam int AW    = $clog2(CELLS);

  logic [ATTR_W-1:0] text_attr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ADDR_TEXT_ATTR) ? CFG_DATA_W'(text_attr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_ADDR_TEXT_ATTR) begin
      text_attr <= pwdata[ATTR_W-1:0];
    end
  end

  tcce_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcce_seq #(
    .ROWS_N    (ROWS_N),
    .COLUMNS_N (COLUMNS_N),
    .CELLS     (CELLS),
    .AW        (AW)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .operation       (operation),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .cursor_position (cursor_position),
    .cell_char       (cell_char),
    .cell_attr       (cell_attr),
    .text_attr       (text_attr),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

endmodule

@@ sv/tcce_ram.sv @@
// tcce_ram: screen cell store, one write port and one registered read port
// depends on tcce_pkg

module tcce_ram import tcce_pkg::*; #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/tcce_seq.sv @@
// tcce_seq: cursor tracking, item sequencer, scroll copy and result register
// depends on tcce_pkg; drives the port of tcce_ram

module tcce_seq import tcce_pkg::*; #(
  parameter int ROWS_N    = 25,
  parameter int COLUMNS_N = 80,
  parameter int CELLS     = ROWS_N * COLUMNS_N,
  parameter int AW        = $clog2(CELLS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [OP_W-1:0]       operation,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [CELL_IDX_W-1:0] cell_index,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [CELL_IDX_W-1:0] cursor_position,
  output logic [CHAR_W-1:0]     cell_char,
  output logic [ATTR_W-1:0]     cell_attr,
  input  logic [ATTR_W-1:0]     text_attr,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [CELL_W-1:0]     ram_wdata,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_raddr,
  input  logic [CELL_W-1:0]     ram_rdata
);

  localparam int CW   = $clog2(CELLS + TAB_STOP);
  localparam int RW   = $clog2(ROWS_N + 1);
  localparam int COLW = $clog2(COLUMNS_N + TAB_STOP);

  tcce_state_t state, state_next;

  logic [CW-1:0]      addr, addr_next;
  logic [AW-1:0]      cp_wa, cp_wa_next;
  logic               pend;
  logic [TAB_N_W-1:0] cnt, cnt_next;
  logic               scroll, scroll_next;
  logic               hit, hit_next;
  logic [RW-1:0]      row, row_next;
  logic [COLW-1:0]    col, col_next;
  logic [CW-1:0]      lin, lin_next;
  logic [CHAR_W-1:0]  rchar, rchar_next;
  logic [ATTR_W-1:0]  rattr, rattr_next;
  logic               load;

  logic [CW-1:0]      stop;
  logic [TAB_N_W-1:0] tab_n, step;
  logic [COLW-1:0]    csum;
  logic               wrap;
  logic [RW-1:0]      nx_row;
  logic [COLW-1:0]    nx_col;
  logic [CW-1:0]      nx_lin;
  logic               nx_scroll;
  logic               in_rng;
  logic [CELL_W-1:0]  blank;

  assign blank      = {text_attr, CH_BLANK};
  assign item_ready = (state == S_IDLE);
  assign in_rng     = (32'(cell_index) < 32'(CELLS));

  // cursor after a print item, before and after the scroll adjustment
  always_comb begin
    stop  = (lin + CW'(TAB_STOP - 1)) & ~CW'(TAB_STOP - 1);
    tab_n = TAB_N_W'(stop - lin);
    step  = (char_code == CH_TAB) ? tab_n : TAB_N_W'(1);
    csum  = col + COLW'(step);
    wrap  = (csum >= COLW'(COLUMNS_N));
    unique case (char_code)
      CH_NEWLINE: begin
        nx_row = row + RW'(1);
        nx_col = '0;
        nx_lin = lin - CW'(col) + CW'(COLUMNS_N);
      end
      CH_RETURN: begin
        nx_row = row;
        nx_col = '0;
        nx_lin = lin - CW'(col);
      end
      default: begin
        nx_row = wrap ? row + RW'(1) : row;
        nx_col = wrap ? csum - COLW'(COLUMNS_N) : csum;
        nx_lin = (char_code == CH_TAB) ? stop : lin + CW'(1);
      end
    endcase
    nx_scroll = (nx_row == RW'(ROWS_N));
    if (nx_scroll) begin
      nx_row = RW'(ROWS_N - 1);
      nx_lin = nx_lin - CW'(COLUMNS_N);
    end
  end

  always_comb begin
    state_next  = state;
    addr_next   = addr;
    cp_wa_next  = cp_wa;
    cnt_next    = cnt;
    scroll_next = scroll;
    hit_next    = hit;
    row_next    = row;
    col_next    = col;
    lin_next    = lin;
    rchar_next  = rchar;
    rattr_next  = rattr;
    load        = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr[AW-1:0];
    ram_wdata   = blank;
    ram_re      = 1'b0;
    ram_raddr   = addr[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        addr_next = addr + CW'(1);
        if (addr == CW'(CELLS - 1)) begin
          addr_next  = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          if (operation == OP_READ) begin
            ram_re     = in_rng;
            ram_raddr  = AW'(cell_index);
            hit_next   = in_rng;
            state_next = S_READ;
          end else begin
            rchar_next  = '0;
            rattr_next  = '0;
            row_next    = nx_row;
            col_next    = nx_col;
            lin_next    = nx_lin;
            scroll_next = nx_scroll;
            if (char_code == CH_TAB) begin
              if (tab_n != '0) begin
                addr_next  = lin;
                cnt_next   = tab_n;
                state_next = S_BLANK;
              end else begin
                state_next = S_DONE;
              end
            end else begin
              if (char_code != CH_NEWLINE && char_code != CH_RETURN) begin
                ram_we    = 1'b1;
                ram_waddr = lin[AW-1:0];
                ram_wdata = {text_attr, char_code};
              end
              if (nx_scroll) begin
                addr_next  = CW'(COLUMNS_N);
                state_next = S_COPY;
              end else begin
                state_next = S_DONE;
              end
            end
          end
        end
      end
      S_READ: begin
        rchar_next = hit ? ram_rdata[CHAR_W-1:0] : '0;
        rattr_next = hit ? ram_rdata[CELL_W-1:CHAR_W] : '0;
        state_next = S_DONE;
      end
      S_BLANK: begin
        ram_we    = (addr < CW'(CELLS));
        addr_next = addr + CW'(1);
        cnt_next  = cnt - TAB_N_W'(1);
        if (cnt == TAB_N_W'(1)) begin
          if (scroll) begin
            addr_next  = CW'(COLUMNS_N);
            state_next = S_COPY;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_COPY: begin
        ram_re     = 1'b1;
        cp_wa_next = AW'(addr - CW'(COLUMNS_N));
        ram_we     = pend;
        ram_waddr  = cp_wa;
        ram_wdata  = ram_rdata;
        addr_next  = addr + CW'(1);
        if (addr == CW'(CELLS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ram_we     = pend;
        ram_waddr  = cp_wa;
        ram_wdata  = ram_rdata;
        addr_next  = CW'(CELLS - COLUMNS_N);
        state_next = S_FILL;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        addr_next = addr + CW'(1);
        if (addr == CW'(CELLS - 1)) begin
          scroll_next = 1'b0;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      addr         <= '0;
      pend         <= 1'b0;
      scroll       <= 1'b0;
      row          <= '0;
      col          <= '0;
      lin          <= '0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      addr   <= addr_next;
      pend   <= (state == S_COPY);
      scroll <= scroll_next;
      row    <= row_next;
      col    <= col_next;
      lin    <= lin_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_wa <= cp_wa_next;
    cnt   <= cnt_next;
    hit   <= hit_next;
    rchar <= rchar_next;
    rattr <= rattr_next;
    if (load) begin
      cursor_position <= CELL_IDX_W'(lin);
      cell_char       <= rchar;
      cell_attr       <= rattr;
    end
  end

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    (row < RW'(ROWS_N)) && (col < COLW'(COLUMNS_N)))
    else $error("cursor row or column off screen");

  a_cursor_linear: assert property (@(posedge clk) disable iff (rst)
    int'(lin) == int'(row) * COLUMNS_N + int'(col))
    else $error("linear cursor disagrees with row and column");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (int'(ram_waddr) < CELLS))
    else $error("screen write outside the cell store");

  a_scroll_reaches_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && addr == CW'(CELLS - 1)) |=> (state == S_DONE && !scroll))
    else $error("scroll did not complete");

  a_done_loads_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!result_valid || result_ready)) |=>
      (result_valid && state == S_IDLE))
    else $error("finished item gave no result");

endmodule
